// ===== sv/gtw_pkg.sv =====
`timescale 1ns / 1ps
// gtw_pkg: shared types, constants and tables of the waypoint heading controller.
// No dependencies; used by every module of the block.
package gtw_pkg;

	localparam int CORDIC_STAGES = 16;	// 8 .. 32
	localparam int SQRT_STEPS    = 32;	// one root bit per step
	localparam int TAB_W         = 5;	// atan table index
	localparam int VW            = 34;	// vector width before normalising
	localparam int CW            = 45;	// CORDIC x/y width
	localparam int ZW            = 34;	// angle accumulator, Q3.30
	localparam int AW            = 17;	// rounded angle, Q3.13
	localparam int REM_W         = 35;	// root remainder
	localparam int NORM_BIT      = 40;	// normalise until max(|x|,|y|) >= 2^40

	// pipeline geometry
	localparam int ANG_END  = 7 + CORDIC_STAGES;
	localparam int DIST_END = 6 + SQRT_STEPS;
	localparam int ALIGN    = (ANG_END > DIST_END) ? ANG_END : DIST_END;
	localparam int PAD_ANG  = ALIGN - ANG_END;
	localparam int PAD_DIST = ALIGN - DIST_END;
	localparam int DEPTH    = ALIGN + 3;

	localparam logic signed [AW:0]   PI_Q13      = 18'sd25736;
	localparam logic signed [AW:0]   TWO_PI_Q13  = 18'sd51472;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIN_GAIN = 3'd0,
		CFG_ANG_GAIN = 3'd1,
		CFG_ANG_LIM  = 3'd2,
		CFG_LIN_LIM  = 3'd3,
		CFG_HEAD_TOL = 3'd4,
		CFG_REACH    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
	} in_t;

	typedef struct packed {
		logic [14:0]        forward_speed;
		logic signed [15:0] turn_rate;
		logic               turning;
		logic               waypoint_reached;
	} out_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;	// answer is forced to zero
	} cordic_t;

	typedef struct packed {
		logic [63:0]      n;	// radicand, consumed two bits a step from the top
		logic [REM_W-1:0] rem;
		logic [31:0]      root;
		logic             dbl;	// operands were halved, root is doubled
	} sqrt_t;

	// atan(2^-i), Q30, rounded
	function automatic logic signed [ZW-1:0] atan_q30(input logic [TAB_W-1:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0: a = 34'sd843314857;
			5'd1: a = 34'sd497837829;
			5'd2: a = 34'sd263043837;
			5'd3: a = 34'sd133525159;
			5'd4: a = 34'sd67021687;
			5'd5: a = 34'sd33543516;
			5'd6: a = 34'sd16775851;
			5'd7: a = 34'sd8388437;
			5'd8: a = 34'sd4194283;
			5'd9: a = 34'sd2097149;
			5'd31: a = 34'sd1;
			default: a = 34'sd1 <<< (5'd30 - i);
		endcase
		return a;
	endfunction

	// left shift that brings the leading one to NORM_BIT
	function automatic logic [5:0] lead_shift(input logic [VW-1:0] m);
		logic [5:0] p;
		p = '0;
		for (int k = 0; k < VW; k++) begin
			if (m[k]) p = 6'(k);
		end
		return 6'(NORM_BIT) - p;
	endfunction

endpackage

// ===== sv/go_to_waypoint_heading_controller_top.sv =====
`timescale 1ns / 1ps
// go_to_waypoint_heading_controller_top: pose-to-command pipeline (yaw, bearing, distance).
// Depends on gtw_pkg, gtw_cordic_cell and gtw_sqrt_cell.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  in       | into      | in_valid/in_stall  | in_data  (gtw_pkg::in_t)
//  out      | out of    | out_valid/out_stall| out_data (gtw_pkg::out_t)
//  cfg      | into      | cfg_we             | cfg_idx, cfg_data
//
// One request per cycle while no result is held at the output; the pipe depth,
// gtw_pkg::DEPTH, is set by the 32-cell square-root chain or the CORDIC chain, whichever
// is longer, plus the front and back stages.
// Reset clears the stage valid bits and loads the register defaults; no clearing pass.
// The whole pipe holds while a result waits at the output with out_stall high.
module go_to_waypoint_heading_controller_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  gtw_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output gtw_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [gtw_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gtw_pkg::CFG_W-1:0]     cfg_data
);

	localparam int N = gtw_pkg::CORDIC_STAGES;
	localparam int VW = gtw_pkg::VW;
	localparam int CW = gtw_pkg::CW;
	localparam int ZW = gtw_pkg::ZW;
	localparam int AW = gtw_pkg::AW;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic [5:0]           sh;
		logic                 zero;
	} vec_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 zero;
	} nvec_t;

	// ---------------- configuration registers ----------------
	logic [15:0] lin_gain_q, ang_gain_q;
	logic [14:0] ang_lim_q, lin_lim_q, head_tol_q;
	logic [30:0] reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q <= 16'd384;
			ang_gain_q <= 16'd77;
			ang_lim_q  <= 15'd1229;
			lin_lim_q  <= 15'd2048;
			head_tol_q <= 15'd410;
			reach_q    <= 31'd13107;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gtw_pkg::CFG_LIN_GAIN: lin_gain_q <= cfg_data[15:0];
				gtw_pkg::CFG_ANG_GAIN: ang_gain_q <= cfg_data[15:0];
				gtw_pkg::CFG_ANG_LIM:  ang_lim_q  <= cfg_data[14:0];
				gtw_pkg::CFG_LIN_LIM:  lin_lim_q  <= cfg_data[14:0];
				gtw_pkg::CFG_HEAD_TOL: head_tol_q <= cfg_data[14:0];
				gtw_pkg::CFG_REACH:    reach_q    <= cfg_data[30:0];
				default: ;	// unused indexes are dropped
			endcase
		end
	end

	// ---------------- flow control ----------------
	// every stage moves together; only a held result at the output stops the pipe
	logic [gtw_pkg::DEPTH:1] vld_q;
	logic adv;

	assign adv = !(vld_q[gtw_pkg::DEPTH] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[gtw_pkg::DEPTH-1:1], in_valid};
	end

	// ---------------- s1: capture ----------------
	gtw_pkg::in_t in_s1;
	always_ff @(posedge clk) begin
		if (adv) in_s1 <= in_data;
	end

	// ---------------- s2: offsets and quaternion products ----------------
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [31:0] ww_s2, xx_s2, yy_s2, zz_s2, xy_s2, wz_s2, xz_s2, wy_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s2 <= 33'(in_s1.target_x) - 33'(in_s1.robot_x);
			dy_s2 <= 33'(in_s1.target_y) - 33'(in_s1.robot_y);
			ww_s2 <= 32'(in_s1.quat_w) * 32'(in_s1.quat_w);
			xx_s2 <= 32'(in_s1.quat_x) * 32'(in_s1.quat_x);
			yy_s2 <= 32'(in_s1.quat_y) * 32'(in_s1.quat_y);
			zz_s2 <= 32'(in_s1.quat_z) * 32'(in_s1.quat_z);
			xy_s2 <= 32'(in_s1.quat_x) * 32'(in_s1.quat_y);
			wz_s2 <= 32'(in_s1.quat_w) * 32'(in_s1.quat_z);
			xz_s2 <= 32'(in_s1.quat_x) * 32'(in_s1.quat_z);
			wy_s2 <= 32'(in_s1.quat_w) * 32'(in_s1.quat_y);
		end
	end

	// ---------------- s3: rotation-matrix terms, gimbal test, halving ----------------
	logic signed [VW-1:0] nrm_c, sid_c, sid_a;
	logic [32:0] ax_c, ay_c;
	logic big_c;
	logic signed [VW-1:0] cx_s3, cy_s3, dx_s3, dy_s3;
	logic yzero_s3, hlf_s3;
	logic [30:0] hx_s3, hy_s3;

	always_comb begin
		nrm_c = VW'(ww_s2) + VW'(xx_s2) + VW'(yy_s2) + VW'(zz_s2);
		sid_c = (VW'(xz_s2) - VW'(wy_s2)) <<< 1;
		sid_a = sid_c[VW-1] ? -sid_c : sid_c;
		ax_c  = dx_s2[32] ? 33'(-dx_s2) : 33'(dx_s2);
		ay_c  = dy_s2[32] ? 33'(-dy_s2) : 33'(dy_s2);
		big_c = (|ax_c[32:31]) || (|ay_c[32:31]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s3    <= VW'(ww_s2) + VW'(xx_s2) - VW'(yy_s2) - VW'(zz_s2);
			cy_s3    <= (VW'(xy_s2) + VW'(wz_s2)) <<< 1;
			yzero_s3 <= sid_a >= nrm_c;	// pitch at +-90 deg, or null quaternion
			dx_s3    <= VW'(dx_s2);
			dy_s3    <= VW'(dy_s2);
			hx_s3    <= big_c ? ax_c[31:1] : ax_c[30:0];
			hy_s3    <= big_c ? ay_c[31:1] : ay_c[30:0];
			hlf_s3   <= big_c;
		end
	end

	// ---------------- s4: squares, leading-one search ----------------
	// vector 0 is yaw, vector 1 is bearing
	logic signed [VW-1:0] vx_c [2];
	logic signed [VW-1:0] vy_c [2];
	logic                 vf_c [2];
	logic [VW-1:0] mx_c [2];
	logic [VW-1:0] abx_c, aby_c;
	vec_t v_s4 [2];
	logic [61:0] hx2_s4, hy2_s4;
	logic hlf_s4;

	always_comb begin
		vx_c[0] = cx_s3;
		vy_c[0] = cy_s3;
		vf_c[0] = yzero_s3;
		vx_c[1] = dx_s3;
		vy_c[1] = dy_s3;
		vf_c[1] = 1'b0;
		abx_c = '0;
		aby_c = '0;
		for (int k = 0; k < 2; k++) begin
			abx_c = vx_c[k][VW-1] ? VW'(-vx_c[k]) : VW'(vx_c[k]);
			aby_c = vy_c[k][VW-1] ? VW'(-vy_c[k]) : VW'(vy_c[k]);
			mx_c[k] = (abx_c > aby_c) ? abx_c : aby_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx2_s4 <= 62'(hx_s3) * 62'(hx_s3);
			hy2_s4 <= 62'(hy_s3) * 62'(hy_s3);
			hlf_s4 <= hlf_s3;
			for (int k = 0; k < 2; k++) begin
				v_s4[k].x    <= vx_c[k];
				v_s4[k].y    <= vy_c[k];
				v_s4[k].sh   <= gtw_pkg::lead_shift(mx_c[k]);
				v_s4[k].zero <= vf_c[k] || (vx_c[k] == '0 && vy_c[k] == '0);
			end
		end
	end

	// ---------------- s5: normalise, root seed ----------------
	nvec_t w_s5 [2];
	gtw_pkg::sqrt_t sq [gtw_pkg::SQRT_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 2; k++) begin
				w_s5[k].x    <= CW'(v_s4[k].x) <<< v_s4[k].sh;
				w_s5[k].y    <= CW'(v_s4[k].y) <<< v_s4[k].sh;
				w_s5[k].zero <= v_s4[k].zero;
			end
			sq[0].n    <= {1'b0, 63'({1'b0, hx2_s4} + {1'b0, hy2_s4})};
			sq[0].rem  <= '0;
			sq[0].root <= '0;
			sq[0].dbl  <= hlf_s4;
		end
	end

	// ---------------- s6: fold into the right half-plane ----------------
	gtw_pkg::cordic_t cc [2][N+1];

	for (genvar g = 0; g < 2; g++) begin : g_fold
		always_ff @(posedge clk) begin
			if (adv) begin
				cc[g][0].zero <= w_s5[g].zero;
				if (w_s5[g].x[CW-1]) begin
					if (!w_s5[g].y[CW-1]) begin
						cc[g][0].x <= w_s5[g].y;
						cc[g][0].y <= -w_s5[g].x;
						cc[g][0].z <= gtw_pkg::HALF_PI_Q30;
					end else begin
						cc[g][0].x <= -w_s5[g].y;
						cc[g][0].y <= w_s5[g].x;
						cc[g][0].z <= -gtw_pkg::HALF_PI_Q30;
					end
				end else begin
					cc[g][0].x <= w_s5[g].x;
					cc[g][0].y <= w_s5[g].y;
					cc[g][0].z <= '0;
				end
			end
		end
	end

	// ---------------- CORDIC chains: one cell per iteration ----------------
	for (genvar g = 0; g < 2; g++) begin : g_vec
		for (genvar s = 0; s < N; s++) begin : g_it
			gtw_cordic_cell u_cell (
				.clk   (clk),
				.en    (adv),
				.stage (gtw_pkg::TAB_W'(s)),
				.d     (cc[g][s]),
				.q     (cc[g][s+1])
			);
		end
	end

	// ---------------- square-root chain: one cell per root bit ----------------
	for (genvar s = 0; s < gtw_pkg::SQRT_STEPS; s++) begin : g_sq
		gtw_sqrt_cell u_cell (
			.clk (clk),
			.en  (adv),
			.d   (sq[s]),
			.q   (sq[s+1])
		);
	end

	// ---------------- round angles (Q30 -> Q3.13), finish distance ----------------
	logic signed [ZW-1:0] zr_c [2];
	logic [2*AW-1:0] ang_q;
	logic [32:0] dist_q;

	always_comb begin
		for (int k = 0; k < 2; k++) zr_c[k] = cc[k][N].z + ZW'(65536);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_q[2*AW-1:AW] <= cc[0][N].zero ? '0 : zr_c[0][ZW-1:17];
			ang_q[AW-1:0]    <= cc[1][N].zero ? '0 : zr_c[1][ZW-1:17];
			dist_q <= sq[gtw_pkg::SQRT_STEPS].dbl ? {sq[gtw_pkg::SQRT_STEPS].root, 1'b0}
			                                       : {1'b0, sq[gtw_pkg::SQRT_STEPS].root};
		end
	end

	// ---------------- line up the two branches ----------------
	logic [2*AW-1:0] ang_al;
	logic [32:0] dist_al;

	if (gtw_pkg::PAD_ANG == 0) begin : g_ang_np
		assign ang_al = ang_q;
	end else begin : g_ang_pad
		logic [2*AW-1:0] pad_q [gtw_pkg::PAD_ANG];
		always_ff @(posedge clk) begin
			if (adv) begin
				pad_q[0] <= ang_q;
				for (int i = 1; i < gtw_pkg::PAD_ANG; i++) pad_q[i] <= pad_q[i-1];
			end
		end
		assign ang_al = pad_q[gtw_pkg::PAD_ANG-1];
	end

	if (gtw_pkg::PAD_DIST == 0) begin : g_dist_np
		assign dist_al = dist_q;
	end else begin : g_dist_pad
		logic [32:0] pad_q [gtw_pkg::PAD_DIST];
		always_ff @(posedge clk) begin
			if (adv) begin
				pad_q[0] <= dist_q;
				for (int i = 1; i < gtw_pkg::PAD_DIST; i++) pad_q[i] <= pad_q[i-1];
			end
		end
		assign dist_al = pad_q[gtw_pkg::PAD_DIST-1];
	end

	// ---------------- e1: heading error, wrapped to [-pi, pi] ----------------
	logic signed [AW:0] err_c;
	logic signed [AW:0] err_e1;
	logic [32:0] dist_e1;
	logic rch_e1;

	always_comb begin
		err_c = (AW+1)'($signed(ang_al[AW-1:0])) - (AW+1)'($signed(ang_al[2*AW-1:AW]));
		if (err_c > gtw_pkg::PI_Q13) err_c = err_c - gtw_pkg::TWO_PI_Q13;
		else if (err_c < -gtw_pkg::PI_Q13) err_c = err_c + gtw_pkg::TWO_PI_Q13;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_e1  <= err_c;
			dist_e1 <= dist_al;
			rch_e1  <= dist_al < {2'b00, reach_q};
		end
	end

	// ---------------- e2: mode decision, gain products ----------------
	logic [AW:0] emag_c;
	logic trn_e2, rch_e2;
	logic signed [34:0] tp_e2;
	logic [48:0] fp_e2;

	assign emag_c = err_e1[AW] ? (AW+1)'(-err_e1) : (AW+1)'(err_e1);

	always_ff @(posedge clk) begin
		if (adv) begin
			trn_e2 <= emag_c > (AW+1)'(head_tol_q);
			tp_e2  <= 35'($signed({1'b0, ang_gain_q})) * 35'(err_e1);
			fp_e2  <= 49'(lin_gain_q) * 49'(dist_e1);
			rch_e2 <= rch_e1;
		end
	end

	// ---------------- e3: round, clamp, output register ----------------
	logic signed [34:0] tr_c, tlim_c;
	logic [49:0] fr_c;
	logic [37:0] fs_c;
	gtw_pkg::out_t out_q;

	always_comb begin
		tlim_c = $signed({20'd0, ang_lim_q});
		tr_c   = (tp_e2 + 35'sd256) >>> 9;
		if (tr_c > tlim_c) tr_c = tlim_c;
		if (tr_c < -tlim_c) tr_c = -tlim_c;
		fr_c = {1'b0, fp_e2} + 50'd2048;
		fs_c = fr_c[49:12];
		if (fs_c > 38'(lin_lim_q)) fs_c = 38'(lin_lim_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.turning          <= trn_e2;
			out_q.waypoint_reached <= rch_e2;
			out_q.turn_rate        <= trn_e2 ? tr_c[15:0] : '0;
			out_q.forward_speed    <= trn_e2 ? '0 : fs_c[14:0];
		end
	end

	assign out_valid = vld_q[gtw_pkg::DEPTH];
	assign out_data  = out_q;

endmodule

// ===== sv/gtw_cordic_cell.sv =====
`timescale 1ns / 1ps
// gtw_cordic_cell: one vectoring CORDIC iteration with its output register.
// Depends on gtw_pkg.
module gtw_cordic_cell (
	input  logic                     clk,
	input  logic                     en,
	input  logic [gtw_pkg::TAB_W-1:0] stage,
	input  gtw_pkg::cordic_t         d,
	output gtw_pkg::cordic_t         q
);

	logic signed [gtw_pkg::CW-1:0] xs, ys;
	logic signed [gtw_pkg::ZW-1:0] a;
	gtw_pkg::cordic_t nx;

	always_comb begin
		xs = d.x >>> stage;
		ys = d.y >>> stage;
		a  = gtw_pkg::atan_q30(stage);
		nx.zero = d.zero;
		if (!d.y[gtw_pkg::CW-1]) begin
			nx.x = d.x + ys;
			nx.y = d.y - xs;
			nx.z = d.z + a;
		end else begin
			nx.x = d.x - ys;
			nx.y = d.y + xs;
			nx.z = d.z - a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nx;
	end

endmodule

// ===== sv/gtw_sqrt_cell.sv =====
`timescale 1ns / 1ps
// gtw_sqrt_cell: one step of the digit-by-digit integer square root, registered.
// Depends on gtw_pkg.
module gtw_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  gtw_pkg::sqrt_t d,
	output gtw_pkg::sqrt_t q
);

	logic [gtw_pkg::REM_W-1:0] rn, trial;
	gtw_pkg::sqrt_t nx;

	always_comb begin
		rn    = {d.rem[gtw_pkg::REM_W-3:0], d.n[63:62]};
		trial = {1'b0, d.root, 2'b01};
		nx.n   = {d.n[61:0], 2'b00};
		nx.dbl = d.dbl;
		if (rn >= trial) begin
			nx.rem  = rn - trial;
			nx.root = {d.root[30:0], 1'b1};
		end else begin
			nx.rem  = rn;
			nx.root = {d.root[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nx;
	end

endmodule

// ===== sv/gtw_checker.sv =====
`timescale 1ns / 1ps
// gtw_checker: port-level checks on the heading controller, bound to the top level.
// Depends on gtw_pkg and go_to_waypoint_heading_controller_top.
module gtw_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input gtw_pkg::out_t out_data
);

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// turning and driving are exclusive
	a_turn_nodrive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.turning |-> out_data.forward_speed == '0)
		else $error("forward speed while turning");

	a_drive_noturn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.turning |-> out_data.turn_rate == '0)
		else $error("turn rate while driving");

	// requests are only held off by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

endmodule

bind go_to_waypoint_heading_controller_top gtw_checker u_chk (.*);
